FILE: rtl/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared types and constants for the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam int          FONT_BYTES = 80;

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_EXEC  = 3'd1;
    localparam logic [2:0] ACT_DROW  = 3'd2;
    localparam logic [2:0] ACT_RMEM  = 3'd3;
    localparam logic [2:0] ACT_RREG  = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNIMP = 2'd1;
    localparam logic [1:0] ERR_OVF   = 2'd2;
    localparam logic [1:0] ERR_UNF   = 2'd3;

    localparam logic [1:0] REG_PROGRAM_START = 2'd0;

    typedef enum logic [4:0] {
        S_INIT,      // memory clearing pass with font fill
        S_IDLE,
        S_RD_WAIT,   // memory read latency for read action
        S_RD_DONE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_FETCH_END,
        S_EXEC,
        S_CLS,
        S_STK_RD,
        S_STK_DONE,
        S_DRAW_RD,
        S_DRAW_WAIT,
        S_DRAW_ROW,
        S_ST_LOOP,
        S_LD_RD,
        S_LD_WAIT,
        S_LD_WR,
        S_OUT
    } t_state;

    // hex font glyph bytes
    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] t [0:79];
        t = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        font_byte = (i < 7'd80) ? t[i] : 8'h00;
    endfunction

endpackage

FILE: rtl/c8ic_ram.sv
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 core: 4 KB memory, registers, return stack and 64x32 frame buffer.
// ----------------------------------------------------------------------------
// Draw walks up to N sprite rows, stopping after the bottom row; FX65 and
// FX55 walk X+1 registers; 00E0 clears all rows at once; all memory access
// goes through the single memory port. One transaction at a time; ready is
// low while busy or while a result waits. After reset a clearing pass
// writes zeros and the font into all of memory; no item is accepted until
// it ends. Configuration is always taken.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_load_data,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_instruction,
    output logic [1:0]  o_error_code,
    output logic [63:0] o_display_row,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_flag_register,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    c8ic_pkg::t_state r_state, n_state;

    logic [11:0] r_pstart, r_pc, r_i;
    logic [7:0]  r_v [16];
    logic [SCW-1:0] r_sc;
    logic [11:0] r_stack [STACK_DEPTH];
    logic [63:0] r_fb [32];
    logic [31:0] r_fbv;          // row valid bits; invalid rows read as zero
    logic [11:0] r_cnt;
    logic [15:0] r_op;
    logic [11:0] r_addr;
    logic [7:0]  r_rnd;
    logic [4:0]  r_j;
    logic        r_hit;

    logic [11:0] r_opc;
    logic [15:0] r_oins;
    logic [1:0]  r_oerr;
    logic [63:0] r_orow;
    logic [7:0]  r_odat;
    logic        r_ovalid;

    // memory port
    logic        m_we;
    logic [11:0] m_addr;
    logic [7:0]  m_wdata, m_rdata;

    c8ic_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == c8ic_pkg::REG_PROGRAM_START) ? {20'd0, r_pstart} : 32'd0;

    wire [3:0]  op_x   = r_op[11:8];
    wire [3:0]  op_y   = r_op[7:4];
    wire [3:0]  op_n   = r_op[3:0];
    wire [7:0]  op_nn  = r_op[7:0];
    wire [11:0] op_nnn = r_op[11:0];
    wire [7:0]  vx = r_v[op_x];
    wire [7:0]  vy = r_v[op_y];
    wire [4:0]  fb_line = vy[4:0] + r_j;
    wire        draw_last = (r_j + 5'd1 == {1'b0, op_n}) || (fb_line == 5'd31);
    wire [6:0]  init_off = r_cnt[6:0] - c8ic_pkg::FONT_BASE[6:0];
    wire        in_font  = (r_cnt >= c8ic_pkg::FONT_BASE) &&
                           (r_cnt < c8ic_pkg::FONT_BASE + 12'(c8ic_pkg::FONT_BYTES));

    assign o_ready = (r_state == c8ic_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_program_counter = r_opc;
    assign o_instruction = r_oins;
    assign o_error_code = r_oerr;
    assign o_display_row = r_orow;
    assign o_read_data = r_odat;
    assign o_flag_register = r_v[15];

    // memory address select
    always_comb begin
        m_we = 1'b0;
        m_addr = r_addr;
        m_wdata = r_v[r_j[3:0]];
        case (r_state)
            c8ic_pkg::S_INIT: begin
                m_we = 1'b1;
                m_addr = r_cnt;
                m_wdata = in_font ? c8ic_pkg::font_byte(init_off) : 8'h00;
            end
            c8ic_pkg::S_IDLE: begin
                m_addr = i_address;
                m_wdata = i_load_data;
                m_we = i_valid && o_ready && (i_action == c8ic_pkg::ACT_LOAD);
            end
            c8ic_pkg::S_FETCH_HI: m_addr = r_pc;
            c8ic_pkg::S_FETCH_LO: m_addr = r_pc + 12'd1;
            // hold the sprite/load address through the read wait
            c8ic_pkg::S_DRAW_RD, c8ic_pkg::S_DRAW_WAIT,
            c8ic_pkg::S_LD_RD, c8ic_pkg::S_LD_WAIT: m_addr = r_i + 12'(r_j);
            c8ic_pkg::S_ST_LOOP: begin
                m_addr = r_i + 12'(r_j);
                m_we = 1'b1;
            end
            default: m_addr = r_addr;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            c8ic_pkg::S_INIT: if (r_cnt == 12'hFFF) n_state = c8ic_pkg::S_IDLE;
            c8ic_pkg::S_IDLE: if (i_valid && o_ready) begin
                if (i_action == c8ic_pkg::ACT_EXEC) n_state = c8ic_pkg::S_FETCH_HI;
                else if (i_action == c8ic_pkg::ACT_RMEM) n_state = c8ic_pkg::S_RD_WAIT;
                else n_state = c8ic_pkg::S_OUT;
            end
            c8ic_pkg::S_RD_WAIT:   n_state = c8ic_pkg::S_RD_DONE;
            c8ic_pkg::S_RD_DONE:   n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_FETCH_HI:  n_state = c8ic_pkg::S_FETCH_LO;
            c8ic_pkg::S_FETCH_LO:  n_state = c8ic_pkg::S_FETCH_END;
            c8ic_pkg::S_FETCH_END: n_state = c8ic_pkg::S_EXEC;
            c8ic_pkg::S_EXEC: begin
                n_state = c8ic_pkg::S_OUT;
                case (r_op[15:12])
                    4'h0: if (r_op == 16'h00E0) n_state = c8ic_pkg::S_CLS;
                    4'hD: if (op_n != 4'd0) n_state = c8ic_pkg::S_DRAW_RD;
                    4'hF: begin
                        if (op_nn == 8'h55) n_state = c8ic_pkg::S_ST_LOOP;
                        else if (op_nn == 8'h65) n_state = c8ic_pkg::S_LD_RD;
                    end
                    default: n_state = c8ic_pkg::S_OUT;
                endcase
            end
            c8ic_pkg::S_CLS:       n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_DRAW_RD:   n_state = c8ic_pkg::S_DRAW_WAIT;
            c8ic_pkg::S_DRAW_WAIT: n_state = c8ic_pkg::S_DRAW_ROW;
            c8ic_pkg::S_DRAW_ROW:
                if (draw_last) n_state = c8ic_pkg::S_OUT;
                else n_state = c8ic_pkg::S_DRAW_RD;
            c8ic_pkg::S_ST_LOOP:
                if (r_j[3:0] == op_x) n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_LD_RD:     n_state = c8ic_pkg::S_LD_WAIT;
            c8ic_pkg::S_LD_WAIT:   n_state = c8ic_pkg::S_LD_WR;
            c8ic_pkg::S_LD_WR:
                if (r_j[3:0] == op_x) n_state = c8ic_pkg::S_OUT;
                else n_state = c8ic_pkg::S_LD_RD;
            c8ic_pkg::S_OUT:       n_state = c8ic_pkg::S_IDLE;
            default:               n_state = c8ic_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= c8ic_pkg::S_INIT;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [8:0]  sum;
        logic [63:0] sprite;
        logic        hit_row;
        sum = 9'd0;
        sprite = 64'd0;
        hit_row = 1'b0;
        if (!i_rst_n) begin
            r_pstart <= 12'h200;
            r_pc <= 12'h200;
            r_i <= 12'd0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            r_sc <= '0;
            r_fbv <= '0;
            r_cnt <= 12'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (cfg_wr && paddr == c8ic_pkg::REG_PROGRAM_START) begin
                r_pstart <= pwdata[11:0];
                r_pc <= pwdata[11:0];
            end
            case (r_state)
                c8ic_pkg::S_INIT: r_cnt <= r_cnt + 12'd1;
                c8ic_pkg::S_IDLE: if (i_valid && o_ready) begin
                    r_addr <= i_address;
                    r_rnd <= i_random_byte;
                    r_op <= 16'd0;
                    r_oerr <= c8ic_pkg::ERR_NONE;
                    r_j <= 5'd0;
                    r_hit <= 1'b0;
                    r_orow <= (i_action == c8ic_pkg::ACT_DROW && r_fbv[i_address[4:0]])
                              ? r_fb[i_address[4:0]] : 64'd0;
                    r_odat <= (i_action == c8ic_pkg::ACT_RREG) ? r_v[i_address[3:0]] : 8'd0;
                end
                c8ic_pkg::S_RD_DONE:  r_odat <= m_rdata;
                c8ic_pkg::S_FETCH_LO: r_op[15:8] <= m_rdata;
                c8ic_pkg::S_FETCH_END: begin
                    r_op[7:0] <= m_rdata;
                    r_pc <= r_pc + 12'd2;
                end
                c8ic_pkg::S_EXEC: begin
                    case (r_op[15:12])
                        4'h0: if (r_op == 16'h00EE) begin
                            if (r_sc == '0) r_oerr <= c8ic_pkg::ERR_UNF;
                            else begin
                                r_sc <= r_sc - 1'b1;
                                r_pc <= r_stack[SPW'(r_sc - 1'b1)];
                            end
                        end
                        4'h1: r_pc <= op_nnn;
                        4'h2: begin
                            if (r_sc < SCW'(STACK_DEPTH)) begin
                                r_stack[SPW'(r_sc)] <= r_pc;
                                r_sc <= r_sc + 1'b1;
                            end else r_oerr <= c8ic_pkg::ERR_OVF;
                            r_pc <= op_nnn;
                        end
                        4'h3: if (vx == op_nn) r_pc <= r_pc + 12'd2;
                        4'h4: if (vx != op_nn) r_pc <= r_pc + 12'd2;
                        4'h5, 4'h9: begin
                            if (op_n != 4'd0) r_oerr <= c8ic_pkg::ERR_UNIMP;
                            else if ((r_op[15:12] == 4'h5) == (vx == vy))
                                r_pc <= r_pc + 12'd2;
                        end
                        4'h6: r_v[op_x] <= op_nn;
                        4'h7: r_v[op_x] <= vx + op_nn;
                        4'h8: begin
                            // flag ops: with X = F only the flag is kept
                            case (op_n)
                                4'h0: r_v[op_x] <= vy;
                                4'h1: r_v[op_x] <= vx | vy;
                                4'h2: r_v[op_x] <= vx & vy;
                                4'h3: r_v[op_x] <= vx ^ vy;
                                4'h4: begin
                                    sum = {1'b0, vx} + {1'b0, vy};
                                    if (op_x != 4'hF) r_v[op_x] <= sum[7:0];
                                    r_v[15] <= {7'd0, sum[8]};
                                end
                                4'h5: begin
                                    if (op_x != 4'hF) r_v[op_x] <= vx - vy;
                                    r_v[15] <= {7'd0, vx >= vy};
                                end
                                4'h6: begin
                                    if (op_x != 4'hF) r_v[op_x] <= vy >> 1;
                                    r_v[15] <= {7'd0, vy[0]};
                                end
                                4'h7: begin
                                    if (op_x != 4'hF) r_v[op_x] <= vy - vx;
                                    r_v[15] <= {7'd0, vy >= vx};
                                end
                                4'hE: begin
                                    if (op_x != 4'hF) r_v[op_x] <= {vy[6:0], 1'b0};
                                    r_v[15] <= {7'd0, vy[7]};
                                end
                                default: r_oerr <= c8ic_pkg::ERR_UNIMP;
                            endcase
                        end
                        4'hA: r_i <= op_nnn;
                        4'hB: r_pc <= op_nnn + {4'd0, r_v[0]};
                        4'hC: r_v[op_x] <= r_rnd & op_nn;
                        4'hD: if (op_n == 4'd0) r_v[15] <= 8'd0;
                        4'hE: r_oerr <= c8ic_pkg::ERR_UNIMP;
                        4'hF: if (op_nn != 8'h55 && op_nn != 8'h65)
                                  r_oerr <= c8ic_pkg::ERR_UNIMP;
                        default: r_oerr <= c8ic_pkg::ERR_NONE;
                    endcase
                end
                c8ic_pkg::S_CLS: r_fbv <= '0;
                c8ic_pkg::S_DRAW_WAIT: ;
                c8ic_pkg::S_DRAW_ROW: begin
                    // VF is written on the last row only, so VX/VY stay put
                    sprite = ({m_rdata, 56'd0}) >> vx[5:0];
                    hit_row = r_fbv[fb_line] && ((r_fb[fb_line] & sprite) != 64'd0);
                    r_fb[fb_line] <= (r_fbv[fb_line] ? r_fb[fb_line] : 64'd0) ^ sprite;
                    r_fbv[fb_line] <= 1'b1;
                    if (hit_row) r_hit <= 1'b1;
                    if (draw_last) r_v[15] <= {7'd0, r_hit | hit_row};
                    r_j <= r_j + 5'd1;
                end
                c8ic_pkg::S_ST_LOOP: r_j <= r_j + 5'd1;
                c8ic_pkg::S_LD_WR: begin
                    r_v[r_j[3:0]] <= m_rdata;
                    r_j <= r_j + 5'd1;
                end
                c8ic_pkg::S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_oins <= r_op;
                    r_opc <= r_pc;
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/chip8_instruction_core_checker.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core_sva
// Port-level checks over time, bound to the core.
// ----------------------------------------------------------------------------
module chip8_instruction_core_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_instruction,
    input logic [1:0]  o_error_code
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_instruction))
        else $error("result dropped while stalled");
    // no new transaction while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    // an error code only comes with an executed instruction
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != c8ic_pkg::ERR_NONE |-> o_instruction != 16'd0)
        else $error("error code without instruction");
    // one transaction in flight
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("second transaction accepted");
endmodule

bind chip8_instruction_core chip8_instruction_core_sva u_sva (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready),
    .o_instruction(o_instruction), .o_error_code(o_error_code)
);

FILE: sim/chip8_instruction_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_checker
// Watches the item, result and configuration channels of the CHIP-8 core,
// runs its own model of memory, registers, stack and frame buffer on every
// accepted item, and compares every accepted result field by field against
// the oldest predicted one.
// ----------------------------------------------------------------------------
module chip8_instruction_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_load_data,
    input  logic [7:0]  i_random_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [11:0] o_program_counter,
    input  logic [15:0] o_instruction,
    input  logic [1:0]  o_error_code,
    input  logic [63:0] o_display_row,
    input  logic [7:0]  o_read_data,
    input  logic [7:0]  o_flag_register,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output logic [11:0] pc_shadow
);

    localparam int RET_DEPTH = 16;

    localparam logic [7:0] GLYPH [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] instr;
        logic [1:0]  err;
        logic [63:0] drow;
        logic [7:0]  rdata;
        logic [7:0]  flag;
    } t_core_result;

    // model state
    logic [7:0]  mem [4096];
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pc;
    logic [11:0] start_addr;
    logic [11:0] ret_stack [RET_DEPTH];
    int          ret_count;
    logic [63:0] fbuf [32];

    t_core_result predicted_results [$];

    assign pc_shadow = pc;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // run one instruction word, returns the error code
    function automatic logic [1:0] run_op(input logic [15:0] op, input logic [7:0] rnd);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [63:0] bits;
        logic        hit;
        int          col;
        int          row;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        vx = vreg[x]; vy = vreg[y];
        run_op = c8ic_pkg::ERR_NONE;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    for (int r = 0; r < 32; r++) fbuf[r] = '0;
                end else if (op == 16'h00EE) begin
                    if (ret_count == 0) begin
                        run_op = c8ic_pkg::ERR_UNF;
                    end else begin
                        ret_count--;
                        pc = ret_stack[ret_count];
                    end
                end
            end
            4'h1: pc = nnn;
            4'h2: begin
                if (ret_count < RET_DEPTH) begin
                    ret_stack[ret_count] = pc;
                    ret_count++;
                end else begin
                    run_op = c8ic_pkg::ERR_OVF;
                end
                pc = nnn;
            end
            4'h3: if (vx == nn) pc = pc + 12'd2;
            4'h4: if (vx != nn) pc = pc + 12'd2;
            4'h5, 4'h9: begin
                if (n != 0) run_op = c8ic_pkg::ERR_UNIMP;
                else if ((op[15:12] == 4'h5) == (vx == vy)) pc = pc + 12'd2;
            end
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        vreg[x] = vx + vy;
                        vreg[15] = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
                    end
                    4'h5: begin
                        vreg[x] = vx - vy;
                        vreg[15] = (vx >= vy) ? 8'd1 : 8'd0;
                    end
                    4'h6: begin
                        vreg[x] = vy >> 1;
                        vreg[15] = {7'd0, vy[0]};
                    end
                    4'h7: begin
                        vreg[x] = vy - vx;
                        vreg[15] = (vy >= vx) ? 8'd1 : 8'd0;
                    end
                    4'hE: begin
                        vreg[x] = vy << 1;
                        vreg[15] = {7'd0, vy[7]};
                    end
                    default: run_op = c8ic_pkg::ERR_UNIMP;
                endcase
            end
            4'hA: ireg = nnn;
            4'hB: pc = nnn + {4'd0, vreg[0]};
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin
                col = int'(vx[5:0]);
                row = int'(vy[4:0]);
                hit = 1'b0;
                for (int j = 0; j < n; j++) begin
                    if (row + j < 32) begin
                        bits = {mem[ireg + 12'(j)], 56'd0} >> col;
                        if ((fbuf[row + j] & bits) != 0) hit = 1'b1;
                        fbuf[row + j] ^= bits;
                    end
                end
                vreg[15] = {7'd0, hit};
            end
            4'hF: begin
                if (nn == 8'h55) begin
                    for (int j = 0; j <= x; j++) mem[ireg + 12'(j)] = vreg[j];
                end else if (nn == 8'h65) begin
                    for (int j = 0; j <= x; j++) vreg[j] = mem[ireg + 12'(j)];
                end else begin
                    run_op = c8ic_pkg::ERR_UNIMP;
                end
            end
            default: run_op = c8ic_pkg::ERR_UNIMP;
        endcase
    endfunction

    // predict the result of one accepted item
    task automatic step_core(input logic [2:0] act, input logic [11:0] addr,
                             input logic [7:0] ld, input logic [7:0] rnd);
        t_core_result res;
        res = '0;
        case (act)
            c8ic_pkg::ACT_LOAD: mem[addr] = ld;
            c8ic_pkg::ACT_EXEC: begin
                res.instr = {mem[pc], mem[pc + 12'd1]};
                pc = pc + 12'd2;
                res.err = run_op(res.instr, rnd);
            end
            c8ic_pkg::ACT_DROW: res.drow = fbuf[addr[4:0]];
            c8ic_pkg::ACT_RMEM: res.rdata = mem[addr];
            c8ic_pkg::ACT_RREG: res.rdata = vreg[addr[3:0]];
            default: ;
        endcase
        res.pc = pc;
        res.flag = vreg[15];
        predicted_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 4096; a++) mem[a] = '0;
            for (int a = 0; a < 80; a++) mem[c8ic_pkg::FONT_BASE + 12'(a)] = GLYPH[a];
            for (int r = 0; r < 16; r++) vreg[r] = '0;
            for (int r = 0; r < 32; r++) fbuf[r] = '0;
            ireg = '0;
            start_addr = 12'h200;
            pc = start_addr;
            ret_count = 0;
            mismatches = 0;
            predicted_results.delete();
        end else begin
            // result transaction
            if (o_valid && i_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_program_counter), 64'd0);
                end else begin
                    t_core_result w;
                    w = predicted_results.pop_front();
                    if (o_program_counter !== w.pc)
                        report_mismatch("program_counter", 64'(o_program_counter),
                                        64'(w.pc));
                    if (o_instruction !== w.instr)
                        report_mismatch("instruction", 64'(o_instruction), 64'(w.instr));
                    if (o_error_code !== w.err)
                        report_mismatch("error_code", 64'(o_error_code), 64'(w.err));
                    if (o_display_row !== w.drow)
                        report_mismatch("display_row", o_display_row, w.drow);
                    if (o_read_data !== w.rdata)
                        report_mismatch("read_data", 64'(o_read_data), 64'(w.rdata));
                    if (o_flag_register !== w.flag)
                        report_mismatch("flag_register", 64'(o_flag_register), 64'(w.flag));
                end
            end
            // configuration write
            if (psel && penable && pwrite && pready &&
                paddr == c8ic_pkg::REG_PROGRAM_START) begin
                start_addr = pwdata[11:0];
                pc = start_addr;
            end
            // item transaction
            if (i_valid && o_ready)
                step_core(i_action, i_address, i_load_data, i_random_byte);
        end
        pending = predicted_results.size();
    end

endmodule

FILE: sim/chip8_instruction_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_tb
// Drives the CHIP-8 core with directed instructions and random programs
// loaded just ahead of the program counter, mixed with loads and readbacks,
// under random stalls on both channels; the checker does all comparison.
// ----------------------------------------------------------------------------
module chip8_instruction_core_tb;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_action;
    logic [11:0] i_address;
    logic [7:0]  i_load_data;
    logic [7:0]  i_random_byte;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_program_counter;
    logic [15:0] o_instruction;
    logic [1:0]  o_error_code;
    logic [63:0] o_display_row;
    logic [7:0]  o_read_data;
    logic [7:0]  o_flag_register;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    logic [11:0] pc_shadow;
    int          sent;
    int          idle_cycles;
    bit          long_hold;
    bit          no_stall;

    chip8_instruction_core dut (.*);

    chip8_instruction_core_checker chk (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("chip8_instruction_core_tb: done, errors");
                $finish;
            end
        end
    end

    // result receiver with random and long hold-offs
    initial begin
        int w;
        bit seen;
        bit held;
        held = 1'b0;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            w = no_stall ? 0 : $urandom_range(0, 6);
            if (long_hold && !held) begin
                w = 300;
                held = 1'b1;
            end
            if (w > 0) begin
                i_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            forever begin
                seen = o_valid;
                @(posedge i_clk);
                if (seen) break;
                @(negedge i_clk);
            end
            @(negedge i_clk);
        end
    end

    // one item transaction; called and returns at a falling edge
    task automatic send(input logic [2:0] act, input logic [11:0] addr,
                        input logic [7:0] ld, input logic [7:0] rnd);
        int  gap;
        bit  rdy;
        gap = no_stall ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action      <= act;
        i_address     <= addr;
        i_load_data   <= ld;
        i_random_byte <= rnd;
        i_valid       <= 1'b1;
        forever begin
            rdy = o_ready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        sent++;
    endtask

    // place an instruction at the predicted PC and run it
    task automatic run_op(input logic [15:0] op);
        logic [11:0] at;
        at = pc_shadow;
        send(c8ic_pkg::ACT_LOAD, at, op[15:8], 8'($urandom));
        send(c8ic_pkg::ACT_LOAD, at + 12'd1, op[7:0], 8'($urandom));
        send(c8ic_pkg::ACT_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // wait for every result, then write program_start
    task automatic set_start(input logic [11:0] value);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= c8ic_pkg::REG_PROGRAM_START;
        pwdata  <= {20'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        op = 16'($urandom);
        case (op[15:12])
            4'h0: case ($urandom_range(0, 3))
                0: op = 16'h00E0;
                1, 2: op = 16'h00EE;
                default: ;
            endcase
            4'h5, 4'h9: if ($urandom_range(0, 3) != 0) op[3:0] = 4'h0;
            4'hA: if ($urandom_range(0, 1) != 0)
                op[11:0] = c8ic_pkg::FONT_BASE + 12'($urandom_range(0, 79));
            4'hF: case ($urandom_range(0, 4))
                0, 1: op[7:0] = 8'h55;
                2, 3: op[7:0] = 8'h65;
                default: ;
            endcase
            default: ;
        endcase
        return op;
    endfunction

    initial begin
        int target;
        sent = 0;
        long_hold = 1'b0;
        no_stall = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = '0;
        i_address = '0;
        i_load_data = '0;
        i_random_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_start(12'h200);

        // directed: field extremes, odd actions, flag and stack corners
        send(c8ic_pkg::ACT_LOAD, 12'hFFF, 8'hFF, 8'h00);
        send(c8ic_pkg::ACT_RMEM, 12'hFFF, 8'h00, 8'hFF);
        send(c8ic_pkg::ACT_RMEM, c8ic_pkg::FONT_BASE, 8'h00, 8'h00);
        send(3'd7, 12'hFFF, 8'hFF, 8'hFF);
        send(3'd5, 12'h000, 8'h00, 8'h00);
        run_op(16'h00EE);                 // return with empty stack
        run_op(16'h6FFF);
        run_op(16'h7F01);                 // add leaves flag alone
        run_op(16'h61FF);
        run_op(16'h8F14);                 // flag register as destination
        run_op(16'hA050);
        run_op(16'hD01F);
        run_op(16'hD015);                 // redraw: collision
        send(c8ic_pkg::ACT_DROW, 12'hFE0, 8'h00, 8'h00);
        run_op(16'h6A3E);
        run_op(16'h6B1F);
        run_op(16'hDAB5);                 // clipped at both edges
        send(c8ic_pkg::ACT_DROW, 12'h01F, 8'h00, 8'h00);
        run_op(16'hAFFE);
        run_op(16'hF355);                 // store wraps past the top
        run_op(16'hF365);
        run_op(16'h5121);
        run_op(16'h800F);
        run_op(16'hE09E);
        run_op(16'hF007);
        run_op(16'h0123);
        run_op(16'h00E0);
        run_op(16'hC0FF);
        run_op(16'hBFFF);
        send(c8ic_pkg::ACT_RREG, 12'hFFF, 8'h00, 8'h00);

        // PC at the top of memory, fetch wraps
        set_start(12'hFFF);
        run_op(16'h7001);
        set_start(12'h000);
        run_op(16'h6055);

        // random programs with noise
        target = sent + 720;
        while (sent < target) begin
            if (sent > target - 600 && sent < target - 590) begin
                // receiver holds off while items keep coming
                long_hold = 1'b1;
            end
            if (sent > target - 400 && sent < target - 395)
                set_start(12'($urandom));
            no_stall = (sent > target - 250 && sent < target - 150);
            case ($urandom_range(0, 19))
                0: begin
                    // deep call chain overflows the stack, then unwinds
                    repeat (17) run_op({4'h2, 12'($urandom)});
                    repeat ($urandom_range(0, 18)) run_op(16'h00EE);
                end
                1, 2, 3, 4: send(3'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
                5: send(c8ic_pkg::ACT_DROW, 12'($urandom), 8'($urandom), 8'($urandom));
                6: send(c8ic_pkg::ACT_RREG, 12'($urandom), 8'($urandom), 8'($urandom));
                default: run_op(random_op());
            endcase
        end

        set_start(12'h200);
        run_op(16'h6123);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("chip8_instruction_core_tb: done, clean");
        end else begin
            $display("chip8_instruction_core_tb: done, errors");
        end
        $finish;
    end

endmodule
